// File: src/crcfr_pkg.sv
package crcfr_pkg;

    // Default longest line, in line bytes, including the closing position.
    localparam int LINE_CAPACITY_DEF = 240;

    // Framing characters.
    localparam logic [7:0] CH_START = 8'h40;  // '@'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_LF    = 8'h0A;  // '\n'
    localparam logic [7:0] CH_CR    = 8'h0D;  // '\r'
    localparam logic [7:0] CH_LIVE  = 8'h52;  // 'R'
    localparam logic [7:0] CH_ACK   = 8'h41;  // 'A'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','

    // CRC-8 polynomial, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_GOOD_LIVE  = 3'd0,
        ST_GOOD_ACK   = 3'd1,
        ST_GOOD_OTHER = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_MALFORMED  = 3'd4
    } t_status;

    // One result word.
    typedef struct packed {
        logic [7:0] computed_check;
        logic [7:0] received_check;
        logic [7:0] payload_len;
        t_status    status;
    } t_result;

    // Width of the output tdata: the result rounded up to whole bytes.
    localparam int RES_W   = $bits(t_result);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // One byte of CRC-8, bit by bit.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Hex character decode: bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

endpackage

// File: src/crcfr_frame.sv
module crcfr_frame
    import crcfr_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W:0] CAP = (CNT_W + 1)'(LINE_CAPACITY);

    logic             r_in_frame, n_in_frame;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic             r_zero_seen, n_zero_seen;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_crc_star, n_crc_star;
    logic             r_star_found, n_star_found;
    logic [CNT_W-1:0] r_len_star, n_len_star;
    logic [1:0]       r_tail, n_tail;
    logic [31:0]      r_hex, n_hex;
    logic             r_hex_ovf, n_hex_ovf;
    logic             r_hex_stop, n_hex_stop;
    logic [15:0]      r_first_two, n_first_two;

    logic [4:0] digit;
    logic [7:0] got;
    logic       room;

    assign digit = hex_decode(i_byte);
    assign room  = (({1'b0, r_byte_count}) + (CNT_W + 1)'(1)) < CAP;
    assign got   = r_hex_ovf ? 8'hFF : r_hex[7:0];

    // Frame state update for one accepted byte.
    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        n_zero_seen  = r_zero_seen;
        n_crc        = r_crc;
        n_crc_star   = r_crc_star;
        n_star_found = r_star_found;
        n_len_star   = r_len_star;
        n_tail       = r_tail;
        n_hex        = r_hex;
        n_hex_ovf    = r_hex_ovf;
        n_hex_stop   = r_hex_stop;
        n_first_two  = r_first_two;
        o_res_valid  = 1'b0;

        if (i_valid) begin
            if (!r_in_frame) begin
                if (i_byte == CH_START) begin
                    n_in_frame   = 1'b1;
                    n_byte_count = '0;
                    n_zero_seen  = 1'b0;
                    n_crc        = '0;
                    n_crc_star   = '0;
                    n_star_found = 1'b0;
                    n_len_star   = '0;
                    n_tail       = '0;
                    n_hex        = '0;
                    n_hex_ovf    = 1'b0;
                    n_hex_stop   = 1'b0;
                    n_first_two  = '0;
                end
            end else if (i_byte == CH_CR) begin
                // Carriage return is skipped inside a frame.
            end else if (i_byte == CH_LF) begin
                n_in_frame  = 1'b0;
                o_res_valid = 1'b1;
            end else if (!room) begin
                // Overlong line: drop the frame without a result.
                n_in_frame = 1'b0;
            end else begin
                if (r_byte_count == '0) begin
                    n_first_two = {i_byte, 8'h00};
                end else if (r_byte_count == CNT_W'(1)) begin
                    n_first_two = {r_first_two[15:8], i_byte};
                end
                if (!r_zero_seen) begin
                    if (i_byte == 8'h00) begin
                        n_zero_seen = 1'b1;
                    end else if (i_byte == CH_STAR) begin
                        n_star_found = 1'b1;
                        n_crc_star   = r_crc;
                        n_len_star   = r_byte_count;
                        n_tail       = '0;
                        n_hex        = '0;
                        n_hex_ovf    = 1'b0;
                        n_hex_stop   = 1'b0;
                    end else if (r_star_found) begin
                        // Only "at least two tail characters" matters.
                        if (r_tail != 2'd2) begin
                            n_tail = r_tail + 2'd1;
                        end
                        if (!r_hex_stop) begin
                            if (!digit[4]) begin
                                n_hex_stop = 1'b1;
                            end else if (r_hex[31:28] != 4'h0) begin
                                n_hex_ovf = 1'b1;
                            end else begin
                                n_hex = {r_hex[27:0], digit[3:0]};
                            end
                        end
                    end
                    if (i_byte != 8'h00) begin
                        n_crc = crc8_byte(r_crc, i_byte);
                    end
                end
                n_byte_count = r_byte_count + CNT_W'(1);
            end
        end
    end

    // Verdict for a closing line feed, built from the state before it.
    always_comb begin
        o_res = '0;
        if (!r_star_found || r_tail != 2'd2) begin
            o_res.status = ST_MALFORMED;
        end else begin
            o_res.payload_len    = 8'(r_len_star);
            o_res.received_check = got;
            o_res.computed_check = r_crc_star;
            if (got != r_crc_star) begin
                o_res.status = ST_MISMATCH;
            end else if (r_len_star >= CNT_W'(2) && r_first_two[7:0] == CH_COMMA
                         && r_first_two[15:8] == CH_LIVE) begin
                o_res.status = ST_GOOD_LIVE;
            end else if (r_len_star >= CNT_W'(2) && r_first_two[7:0] == CH_COMMA
                         && r_first_two[15:8] == CH_ACK) begin
                o_res.status = ST_GOOD_ACK;
            end else begin
                o_res.status = ST_GOOD_OTHER;
            end
        end
    end

    // Frame flag is control state; the rest is cleared when a frame opens.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte_count <= n_byte_count;
        r_zero_seen  <= n_zero_seen;
        r_crc        <= n_crc;
        r_crc_star   <= n_crc_star;
        r_star_found <= n_star_found;
        r_len_star   <= n_len_star;
        r_tail       <= n_tail;
        r_hex        <= n_hex;
        r_hex_ovf    <= n_hex_ovf;
        r_hex_stop   <= n_hex_stop;
        r_first_two  <= n_first_two;
    end

endmodule

// File: src/crcfr_out_buf.sv
module crcfr_out_buf
    import crcfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_v && i_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // Occupancy of the main and skid entries.
    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        if (pop) begin
            if (r_skid_v) begin
                n_skid_v = i_push;
            end else begin
                n_main_v = i_push;
            end
        end else if (!r_main_v) begin
            n_main_v = i_push;
        end else if (i_push) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    // Result words move from skid to main as the main word is taken.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_v) begin
                r_main <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (!r_main_v) begin
            if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// File: src/crc8_framed_line_receiver.sv
// CRC-8 checked line receiver for a serial byte stream.
// Input channel (i_s_*): one received byte per word in tdata. Bytes outside
// a frame are dropped until '@'; inside a frame '\r' is skipped and '\n'
// closes the frame. Every input word is consumed, most produce no result.
// Output channel (o_m_*): one result word per frame closed by '\n', holding
// the status, the payload length before the last star, the received check
// byte and the CRC-8 computed over the payload.
// Throughput: one byte per cycle while the output buffer has room. The frame
// state updates in the cycle the byte is accepted; the byte-wide CRC and hex
// update are combinational logic. A result is registered into the output
// buffer when its '\n' word is accepted.
// Output stalls: results wait in a two-word output buffer. Input ready drops
// only when both words are occupied, and it rises again the cycle after the
// receiver takes a word. A frame that grows to LINE_CAPACITY bytes is dropped
// with no result.
// Reset (i_rst_n low, synchronous): the block returns to waiting for '@' and
// the output buffer is emptied.
module crc8_framed_line_receiver
    import crcfr_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] rx_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // [2:0] status, [10:3] payload_len,
                                              // [18:11] received_check,
                                              // [26:19] computed_check, rest zero
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_word;

    assign accept = i_s_tvalid && o_s_tready;

    // Frame tracking, CRC and check parsing.
    crcfr_frame #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_byte     (i_s_tdata),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // Result register with skid entry.
    crcfr_out_buf u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_data (res),
        .o_ready(o_s_tready),
        .o_valid(o_m_tvalid),
        .i_ready(i_m_tready),
        .o_data (out_word)
    );

    assign o_m_tdata = M_TDATA_W'(out_word);

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RST_CYCLES   = 7;
    localparam int TOTAL_BYTES  = 1850;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 40;

    // Ways of writing the check field after the star.
    typedef enum int {
        CK_HEX_LO,
        CK_HEX_UP,
        CK_LEAD0,
        CK_OVF,
        CK_TRAIL
    } t_check_style;

    typedef logic [7:0] t_bytes[$];

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata  = 8'h00;   // [7:0] rx_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;            // [2:0] status, [10:3] payload_len,
                                                // [18:11] received_check,
                                                // [26:19] computed_check

    // Bytes waiting to be offered and frame verdicts waiting to come out.
    t_bytes  byte_q;
    t_result verdict_q[$];

    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic hold_armed     = 1'b0;
    int   hold_cnt       = 0;
    int   cycle_cnt      = 0;
    int   err_cnt        = 0;
    int   bytes_queued   = 0;
    int   bytes_taken    = 0;
    int   frames_sent    = 0;
    int   results_seen   = 0;
    int   status_hits[8];

    // Line state of the predictor.
    logic        in_line     = 1'b0;
    int          line_cnt    = 0;
    logic        nul_seen    = 1'b0;
    logic [7:0]  crc_acc     = 8'h00;
    logic [7:0]  crc_at_star = 8'h00;
    logic        star_seen   = 1'b0;
    int          star_pos    = 0;
    int          tail_len    = 0;
    logic [31:0] hex_acc     = 32'h0;
    logic        hex_ovf     = 1'b0;
    logic        hex_done    = 1'b0;
    logic [15:0] lead_pair   = 16'h0;

    crc8_framed_line_receiver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // CRC-8, polynomial 0x07, shifted in one bit at a time, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        int         i;
        r = crc;
        for (i = 7; i >= 0; i--) begin
            if (r[7] ^ b[i]) begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Works out what one accepted byte does to the line and queues a verdict
    // when it closes a frame.
    task automatic absorb_byte(input logic [7:0] c);
        t_result v;
        int      d;
        if (!in_line) begin
            if (c == CH_START) begin
                in_line     = 1'b1;
                line_cnt    = 0;
                nul_seen    = 1'b0;
                crc_acc     = 8'h00;
                crc_at_star = 8'h00;
                star_seen   = 1'b0;
                star_pos    = 0;
                tail_len    = 0;
                hex_acc     = 32'h0;
                hex_ovf     = 1'b0;
                hex_done    = 1'b0;
                lead_pair   = 16'h0;
            end
        end else if (c == CH_LF) begin
            in_line = 1'b0;
            v = '0;
            if (!star_seen || tail_len < 2) begin
                v.status = ST_MALFORMED;
            end else begin
                v.payload_len    = 8'(star_pos);
                v.received_check = hex_ovf ? 8'hFF : hex_acc[7:0];
                v.computed_check = crc_at_star;
                if (v.received_check != v.computed_check) begin
                    v.status = ST_MISMATCH;
                end else if (star_pos >= 2 && lead_pair == {CH_LIVE, CH_COMMA}) begin
                    v.status = ST_GOOD_LIVE;
                end else if (star_pos >= 2 && lead_pair == {CH_ACK, CH_COMMA}) begin
                    v.status = ST_GOOD_ACK;
                end else begin
                    v.status = ST_GOOD_OTHER;
                end
            end
            verdict_q.push_back(v);
        end else if (c != CH_CR) begin
            if (line_cnt + 1 >= LINE_CAPACITY_DEF) begin
                // Over-long line: dropped without a verdict.
                in_line = 1'b0;
            end else begin
                if (line_cnt == 0) begin
                    lead_pair = {c, 8'h00};
                end else if (line_cnt == 1) begin
                    lead_pair[7:0] = c;
                end
                // Everything from the first zero byte on only counts towards length.
                if (!nul_seen) begin
                    if (c == 8'h00) begin
                        nul_seen = 1'b1;
                    end else begin
                        if (c == CH_STAR) begin
                            star_seen   = 1'b1;
                            crc_at_star = crc_acc;
                            star_pos    = line_cnt;
                            tail_len    = 0;
                            hex_acc     = 32'h0;
                            hex_ovf     = 1'b0;
                            hex_done    = 1'b0;
                        end else if (star_seen) begin
                            if (tail_len < 255) begin
                                tail_len++;
                            end
                            if (!hex_done) begin
                                if (c >= "0" && c <= "9") begin
                                    d = int'(c) - int'("0");
                                end else if (c >= "a" && c <= "f") begin
                                    d = int'(c) - int'("a") + 10;
                                end else if (c >= "A" && c <= "F") begin
                                    d = int'(c) - int'("A") + 10;
                                end else begin
                                    d = -1;
                                end
                                if (d < 0) begin
                                    hex_done = 1'b1;
                                end else if (hex_acc > 32'h0FFF_FFFF) begin
                                    hex_ovf = 1'b1;
                                end else begin
                                    hex_acc = {hex_acc[27:0], 4'(d)};
                                end
                            end
                        end
                        crc_acc = crc8_step(crc_acc, c);
                    end
                end
                line_cnt++;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input int unsigned got_v,
                                   input int unsigned want_v);
        if (err_cnt < MAX_REPORTS) begin
            $display("ERROR at %0t ns: result %0d, %s is %0d, expected %0d",
                     $time, results_seen, field, got_v, want_v);
        end
        err_cnt++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic put_line(input t_bytes line);
        put_byte(CH_START);
        foreach (line[i]) begin
            put_byte(line[i]);
        end
        put_byte(CH_LF);
        frames_sent++;
    endtask

    function automatic t_bytes str_bytes(input string s);
        t_bytes q;
        int     i;
        for (i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // Appends the star and a check field built from the CRC of the body,
    // optionally spoilt by an xor mask.
    function automatic t_bytes with_check(input t_bytes body, input t_check_style style,
                                          input logic [7:0] flip);
        t_bytes     line;
        logic [7:0] acc;
        string      s;
        int         i;
        acc = 8'h00;
        foreach (body[k]) begin
            acc = crc8_step(acc, body[k]);
        end
        acc = acc ^ flip;
        case (style)
            CK_HEX_LO: s = $sformatf("%02x", acc);
            CK_HEX_UP: begin
                s = $sformatf("%02x", acc);
                s = s.toupper();
            end
            CK_LEAD0: begin
                s = $sformatf("000%02x", acc);
                s = s.toupper();
            end
            CK_OVF:    s = $sformatf("f%08x", $urandom());
            default:   s = $sformatf("%02x;z", acc);
        endcase
        line = body;
        line.push_back(CH_STAR);
        for (i = 0; i < s.len(); i++) begin
            line.push_back(s[i]);
        end
        return line;
    endfunction

    // One random frame, mostly well formed, with some noise in front and the
    // occasional broken check field, stray carriage return or zero byte.
    task automatic random_frame(input int len_max);
        t_bytes     body;
        t_bytes     line;
        int         n;
        int         i;
        logic [7:0] b;
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) begin
            put_byte(8'($urandom_range(255)));
        end
        case ($urandom_range(9))
            0, 1, 2: body = str_bytes("R,");
            3, 4:    body = str_bytes("A,");
            5:       body.push_back($urandom_range(1) ? CH_LIVE : CH_ACK);
            default: ;
        endcase
        if ($urandom_range(99) == 0) begin
            n = $urandom_range(236, 248);
        end else if ($urandom_range(49) == 0) begin
            n = $urandom_range(150, 232);
        end else begin
            n = $urandom_range(len_max);
        end
        for (i = 0; i < n; i++) begin
            if ($urandom_range(6) == 0) begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_LF) begin
                    b = 8'h8A;
                end
            end else begin
                b = 8'($urandom_range(32, 126));
            end
            body.push_back(b);
        end
        case ($urandom_range(15))
            0, 1, 2, 3: line = with_check(body, CK_HEX_LO, 8'h00);
            8:          line = with_check(body, CK_LEAD0, 8'h00);
            9:          line = with_check(body, CK_TRAIL, 8'h00);
            10:         line = with_check(body, CK_OVF, 8'h00);
            11:         line = with_check(body, CK_HEX_LO, 8'($urandom_range(1, 255)));
            12:         line = body;
            13: begin
                line = body;
                line.push_back(CH_STAR);
                line.push_back(8'($urandom_range(48, 70)));
            end
            default:    line = with_check(body, CK_HEX_UP, 8'h00);
        endcase
        if ($urandom_range(7) == 0 && line.size() != 0) begin
            line.insert($urandom_range(line.size() - 1), CH_CR);
        end
        if ($urandom_range(15) == 0 && line.size() != 0) begin
            line.insert($urandom_range(line.size() - 1), 8'h00);
        end
        put_line(line);
    endtask

    // Waits until every queued byte has gone in and every verdict has come out.
    task automatic wait_idle();
        while (byte_q.size() != 0 || i_s_tvalid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Byte driver: one word per handshake, held until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                absorb_byte(i_s_tdata);
                bytes_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= byte_q.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off, counted in cycles once it has been armed.
    always @(posedge i_clk) begin
        if (hold_armed && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
        end
    end

    // Result monitor: compares each result word with the oldest verdict.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[RES_W-1:0];
                results_seen++;
                if ((o_m_tdata >> RES_W) != 0) begin
                    report_mismatch("padding", int'(o_m_tdata >> RES_W), 0);
                end
                if (verdict_q.size() == 0) begin
                    report_mismatch("status of a result with no frame closed", got.status, 0);
                end else begin
                    want = verdict_q.pop_front();
                    status_hits[want.status]++;
                    if (got.status != want.status) begin
                        report_mismatch("status", got.status, want.status);
                    end
                    if (got.payload_len != want.payload_len) begin
                        report_mismatch("payload_len", got.payload_len, want.payload_len);
                    end
                    if (got.received_check != want.received_check) begin
                        report_mismatch("received_check", got.received_check,
                                        want.received_check);
                    end
                    if (got.computed_check != want.computed_check) begin
                        report_mismatch("computed_check", got.computed_check,
                                        want.computed_check);
                    end
                end
            end
            i_m_tready <= !(hold_armed && hold_cnt < HOLD_CYCLES)
                          && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_cnt, verdict_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus: directed corner cases, an output hold, then random traffic.
    initial begin : stimulus
        t_bytes body;
        int     ph;
        int     rand_base;
        int     rand_span;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stray bytes outside a frame are ignored.
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CH_LF);
        put_byte(CH_CR);
        put_byte(CH_STAR);
        // Empty payload, no star at all, and a one-character tail.
        put_line(str_bytes("*00"));
        put_line(str_bytes(""));
        put_line(str_bytes("*5"));
        // Live and ack frames, a one-byte payload, trailing text after the digits.
        put_line(with_check(str_bytes("R,1"), CK_HEX_UP, 8'h00));
        put_line(with_check(str_bytes("A,ok"), CK_HEX_LO, 8'h00));
        put_line(with_check(str_bytes("R"), CK_LEAD0, 8'h00));
        put_line(with_check(str_bytes("R,"), CK_TRAIL, 8'h00));
        // '@' and an earlier star inside the line; only the last star counts.
        put_line(with_check(str_bytes("A,@*x"), CK_HEX_LO, 8'h00));
        // Wrong check, no hex digits, and a hex value that overflows.
        put_line(with_check(str_bytes("R,9"), CK_HEX_UP, 8'h5A));
        put_line(str_bytes("R,9*zz"));
        put_line(with_check(str_bytes("A,"), CK_OVF, 8'h00));
        // Carriage returns are skipped anywhere in the line.
        put_line(str_bytes("R,\r5*\r00"));
        // A zero byte before the star hides it; after the check it is harmless.
        body = str_bytes("A,7");
        body.push_back(8'h00);
        body.push_back(CH_STAR);
        body.push_back("z");
        body.push_back("z");
        put_line(body);
        body = with_check(str_bytes("R,5"), CK_HEX_UP, 8'h00);
        body.push_back(8'h00);
        body.push_back("x");
        put_line(body);
        // Longest line that still yields a verdict, then one byte too many.
        body = str_bytes("R,");
        while (body.size() < LINE_CAPACITY_DEF - 4) begin
            body.push_back(8'($urandom_range(48, 122)));
        end
        put_line(with_check(body, CK_HEX_LO, 8'h00));
        body.delete();
        while (body.size() < LINE_CAPACITY_DEF) begin
            body.push_back(8'($urandom_range(128, 255)));
        end
        put_line(body);
        put_line(str_bytes("*00"));
        wait_idle();

        // Hold the output off so the result buffer fills and input stalls.
        @(negedge i_clk);
        hold_armed = 1'b1;
        repeat (30) random_frame(4);
        wait_idle();

        // Random traffic under four idling patterns, draining between them.
        rand_base = bytes_queued;
        rand_span = TOTAL_BYTES - rand_base;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 52;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 52;
                end
                default: begin
                    src_idle_pct   = 33;
                    sink_stall_pct = 33;
                end
            endcase
            while (bytes_queued - rand_base < rand_span * (ph + 1) / 4) begin
                random_frame(24);
            end
            wait_idle();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d framed lines: corner cases, a long output hold",
                 bytes_taken, frames_sent);
        $display("and random traffic under four stall patterns; %0d verdicts checked %s",
                 results_seen,
                 $sformatf("(live %0d, ack %0d, other %0d, bad check %0d, malformed %0d).",
                           status_hits[ST_GOOD_LIVE], status_hits[ST_GOOD_ACK],
                           status_hits[ST_GOOD_OTHER], status_hits[ST_MISMATCH],
                           status_hits[ST_MALFORMED]));
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
